// File: src/swk_pkg.sv
package swk_pkg;

  // CORDIC datapath widths
  localparam int unsigned VecW   = 36;  // wheel vector and CORDIC x/y
  localparam int unsigned AngW   = 20;  // accumulated angle, Q.16 rad
  localparam int unsigned SpdW   = 20;  // raw wheel speed, Q12.8
  localparam int unsigned NumW   = 36;  // speed times limit
  localparam int unsigned AtanLen = 24;

  localparam logic signed [AngW-1:0] HalfPiQ16  = 20'sd102944;
  localparam logic signed [15:0]     PiQ13      = 16'sd25736;
  localparam logic [15:0]            InvGainQ16 = 16'd39797;

  // configuration register indexes
  localparam logic [3:0] CfgHalfLength = 4'd0;
  localparam logic [3:0] CfgHalfWidth  = 4'd1;
  localparam logic [3:0] CfgInvRadius  = 4'd2;
  localparam logic [3:0] CfgMaxSpeed   = 4'd3;

  localparam logic [1:0] LastWheel = 2'd3;

  // arctangent of 2^-i in Q.16 rad
  function automatic logic [AngW-1:0] atan_lut(input logic [4:0] idx);
    logic [AngW-1:0] r;
    unique case (idx)
      5'd0:    r = 20'd51472;
      5'd1:    r = 20'd30386;
      5'd2:    r = 20'd16055;
      5'd3:    r = 20'd8150;
      5'd4:    r = 20'd4091;
      5'd5:    r = 20'd2047;
      5'd6:    r = 20'd1024;
      5'd7:    r = 20'd512;
      5'd8:    r = 20'd256;
      5'd9:    r = 20'd128;
      5'd10:   r = 20'd64;
      5'd11:   r = 20'd32;
      5'd12:   r = 20'd16;
      5'd13:   r = 20'd8;
      5'd14:   r = 20'd4;
      5'd15:   r = 20'd2;
      5'd16:   r = 20'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: src/swk_cordic.sv
module swk_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [swk_pkg::VecW-1:0]    x_i,
  input  logic signed [swk_pkg::VecW-1:0]    y_i,
  output logic                               done_o,
  output logic signed [swk_pkg::VecW-1:0]    x_o,
  output logic signed [swk_pkg::AngW-1:0]    z_o
);
  import swk_pkg::*;

  localparam int unsigned CntW = $clog2(CORDIC_STEPS + 1);

  logic signed [VecW-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [AngW-1:0] z_q, z_d, ang;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d, done_q, done_d;

  // one micro-rotation per cycle through the shared shifter and adders
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dx     = y_q >>> cnt_q;
    dy     = x_q >>> cnt_q;
    ang    = $signed(atan_lut(5'(cnt_q)));
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      // fold the left half plane onto the right one
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_d = y_i;
          y_d = -x_i;
          z_d = HalfPiQ16;
        end else begin
          x_d = -y_i;
          y_d = x_i;
          z_d = -HalfPiQ16;
        end
      end else begin
        x_d = x_i;
        y_d = y_i;
        z_d = '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + ang;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - ang;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign z_o    = z_q;

endmodule

// File: src/swk_divider.sv
module swk_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [swk_pkg::NumW-1:0]      num_i,
  input  logic [swk_pkg::SpdW-1:0]      den_i,
  output logic                          done_o,
  output logic [swk_pkg::NumW-1:0]      quot_o
);
  import swk_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [SpdW:0]   rem_q, rem_d, trial;
  logic [SpdW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;

  // restoring division, one quotient bit per cycle
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[SpdW-1:0], quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: src/swerve_wheel_kinematics.sv
// Swerve drive inverse kinematics for four wheels (FL, FR, RL, RR).
// Input channel in_valid_i/in_ready_o takes one body velocity request
// (velocity_x, velocity_y, yaw_rate). Output channel out_valid_o/out_ready_i
// then delivers four wheel results in wheel order, last_wheel_o set on RR.
// Configuration channel cfg_valid_i/cfg_ready_o writes half_length (0),
// half_width (1), inv_wheel_radius (2) and max_wheel_speed (3); other
// indexes are dropped. Write only while the block is idle.
// One request is handled at a time; in_ready_o is high only when idle.
// Per wheel the vector phase runs CORDIC_STEPS micro-rotations (16 by
// default) on the shared CORDIC unit, one per cycle; a zero vector skips it.
// Each result then passes S_NSEL and, when speeds are normalized, the
// 36-step divider before it is offered in S_OUT.
// A stalled receiver holds the current result; the sequencer waits.
// Reset restores the default geometry and limit and empties the block.
module swerve_wheel_kinematics #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] velocity_x_i,
  input  logic signed [15:0] velocity_y_i,
  input  logic signed [15:0] yaw_rate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         wheel_index_o,
  output logic signed [15:0] steer_angle_o,
  output logic [15:0]        drive_speed_o,
  output logic               last_wheel_o
);
  import swk_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_VEC    = 10'b0000000010,
    S_CHK    = 10'b0000000100,
    S_CWAIT  = 10'b0000001000,
    S_MAG    = 10'b0000010000,
    S_SPD    = 10'b0000100000,
    S_NSEL   = 10'b0001000000,
    S_DSTART = 10'b0010000000,
    S_DWAIT  = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] half_len_q, half_wid_q, inv_rad_q, max_spd_q;
  logic signed [15:0] vx_q, vy_q, yaw_q;
  logic [1:0] wheel_q, wheel_d;
  logic signed [VecW-1:0] cx_q, cy_q;
  logic signed [32:0] wl, ww;
  logic signed [VecW-1:0] vx_ext, vy_ext, wl_ext, ww_ext;
  logic [SpdW-1:0] spd_q [4];
  logic signed [15:0] ang_q [4];
  logic [SpdW-1:0] largest_q, spd_new;
  logic [34:0] mag_q, g_pos;
  logic [50:0] mag_prod, spd_prod;
  logic signed [AngW:0] z_rnd;
  logic signed [AngW-1:0] ang_sh;
  logic signed [15:0] ang_clip;
  logic [NumW-1:0] num_q, quot;
  logic [15:0] fin_q;
  logic norm;

  logic cord_start, cord_done, div_start, div_done;
  logic signed [VecW-1:0] cord_x;
  logic signed [AngW-1:0] cord_z;

  swk_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cord_start),
    .x_i    (cx_q),
    .y_i    (cy_q),
    .done_o (cord_done),
    .x_o    (cord_x),
    .z_o    (cord_z)
  );

  swk_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (largest_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cord_start  = (state_q == S_CHK) && !((cx_q == '0) && (cy_q == '0));
  assign div_start   = (state_q == S_DSTART);
  assign norm        = largest_q > {{(SpdW-16){1'b0}}, max_spd_q};

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_len_q <= 16'd24183;
      half_wid_q <= 16'd8356;
      inv_rad_q  <= 16'd32768;
      max_spd_q  <= 16'd2560;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgHalfLength) half_len_q <= cfg_data_i;
      if (cfg_index_i == CfgHalfWidth)  half_wid_q <= cfg_data_i;
      if (cfg_index_i == CfgInvRadius)  inv_rad_q  <= cfg_data_i;
      if (cfg_index_i == CfgMaxSpeed)   max_spd_q  <= cfg_data_i;
    end
  end

  // form the wheel ground vector
  assign wl     = yaw_q * $signed({1'b0, half_len_q});
  assign ww     = yaw_q * $signed({1'b0, half_wid_q});
  assign vx_ext = VecW'(vx_q) <<< 15;
  assign vy_ext = VecW'(vy_q) <<< 15;
  assign wl_ext = VecW'(wl);
  assign ww_ext = VecW'(ww);

  // scale magnitude into wheel speed, round and clip the angle
  assign g_pos    = cord_x[VecW-1] ? '0 : cord_x[34:0];
  assign mag_prod = 51'(g_pos) * 51'(InvGainQ16);
  assign spd_prod = 51'(mag_q) * 51'(inv_rad_q);
  assign spd_new  = spd_prod[50:31];
  assign z_rnd    = (AngW+1)'(cord_z) + (AngW+1)'(4);
  assign ang_sh   = AngW'(z_rnd >>> 3);
  always_comb begin
    if (ang_sh > AngW'(PiQ13))       ang_clip = PiQ13;
    else if (ang_sh < -AngW'(PiQ13)) ang_clip = -PiQ13;
    else                             ang_clip = ang_sh[15:0];
  end

  // sequence the wheels
  always_comb begin
    state_d = state_q;
    wheel_d = wheel_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) begin
        state_d = S_VEC;
        wheel_d = '0;
      end
      S_VEC:    state_d = S_CHK;
      S_CHK:    begin
        if ((cx_q == '0) && (cy_q == '0)) begin
          if (wheel_q == LastWheel) begin
            state_d = S_NSEL;
            wheel_d = '0;
          end else begin
            state_d = S_VEC;
            wheel_d = wheel_q + 1'b1;
          end
        end else begin
          state_d = S_CWAIT;
        end
      end
      S_CWAIT:  if (cord_done) state_d = S_MAG;
      S_MAG:    state_d = S_SPD;
      S_SPD:    begin
        if (wheel_q == LastWheel) begin
          state_d = S_NSEL;
          wheel_d = '0;
        end else begin
          state_d = S_VEC;
          wheel_d = wheel_q + 1'b1;
        end
      end
      S_NSEL:   state_d = norm ? S_DSTART : S_OUT;
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT:  if (div_done) state_d = S_OUT;
      S_OUT:    if (out_ready_i) begin
        if (wheel_q == LastWheel) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_NSEL;
          wheel_d = wheel_q + 1'b1;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wheel_q <= '0;
    end else begin
      state_q <= state_d;
      wheel_q <= wheel_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      vx_q      <= velocity_x_i;
      vy_q      <= velocity_y_i;
      yaw_q     <= yaw_rate_i;
      largest_q <= '0;
    end
    if (state_q == S_VEC) begin
      cx_q <= wheel_q[0] ? vx_ext + ww_ext : vx_ext - ww_ext;
      cy_q <= wheel_q[1] ? vy_ext - wl_ext : vy_ext + wl_ext;
    end
    if ((state_q == S_CHK) && (cx_q == '0) && (cy_q == '0)) begin
      spd_q[wheel_q] <= '0;
      ang_q[wheel_q] <= '0;
    end
    if ((state_q == S_CWAIT) && cord_done) begin
      mag_q          <= mag_prod[50:16];
      ang_q[wheel_q] <= ang_clip;
    end
    if (state_q == S_MAG) begin
      spd_q[wheel_q] <= spd_new;
      if (spd_new > largest_q) largest_q <= spd_new;
    end
    if (state_q == S_NSEL) begin
      num_q <= NumW'(spd_q[wheel_q]) * NumW'(max_spd_q);
      fin_q <= (spd_q[wheel_q] > SpdW'(16'hFFFF)) ? 16'hFFFF : spd_q[wheel_q][15:0];
    end
    if ((state_q == S_DWAIT) && div_done) begin
      fin_q <= quot[15:0];
    end
  end

  assign wheel_index_o = wheel_q;
  assign steer_angle_o = ang_q[wheel_q];
  assign drive_speed_o = fin_q;
  assign last_wheel_o  = (wheel_q == LastWheel);

endmodule
